// ----- sv/ech_pkg.sv -----
`timescale 1ns / 1ps

package ech_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int PATH_DEPTH   = 1025;

   localparam int VERT_W = $clog2(MAX_VERTICES);
   localparam int CFG_W  = 6;
   localparam int ADDR_W = $clog2(PATH_DEPTH);
   localparam int CNT_W  = $clog2(PATH_DEPTH + 1);

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;

   localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(32);

   typedef struct packed {
      logic [1:0]        command;
      logic [VERT_W-1:0] from_vertex;
      logic [VERT_W-1:0] to_vertex;
   } req_type;

   typedef struct packed {
      logic [VERT_W-1:0] vertex;
      logic              last;
      logic              empty_res;
   } rsp_type;

endpackage

// ----- sv/ech_ffs.sv -----
`timescale 1ns / 1ps

// lowest set bit of an adjacency row
module ech_ffs import ech_pkg::*; (
   input  logic [MAX_VERTICES-1:0] row,
   output logic                    found,
   output logic [VERT_W-1:0]       index,
   output logic [MAX_VERTICES-1:0] lowest
);

   always_comb begin
      lowest = row & (~row + MAX_VERTICES'(1));
      found  = |row;
      index  = '0;
      // lowest is one-hot, so or-ing the positions gives its index
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (lowest[i]) begin
            index = index | VERT_W'(i);
         end
      end
   end

endmodule

// ----- sv/euler_circuit_hierholzer.sv -----
`timescale 1ns / 1ps

// directed euler circuit builder using hierholzer's walk. add requests set a bit in a
// 32 x 32 adjacency memory (duplicates merge, edges outside the vertex count are dropped)
// and do one row read and one write back; a dropped edge goes straight back to idle. a run
// request clears the previous circuit and walks from its start vertex: each step reads
// the top vertex's row, written back if it takes an edge; one step per edge taken plus
// one per vertex popped into the circuit store. fetch requests return the circuit in walk
// order, one vertex each, and may wait on the response side; the final vertex has last set
// and a fetch with nothing left returns empty_res. the response sits in an output register,
// so add and run requests go on while a fetched vertex waits to be taken. adjacency rows
// are cleared at reset through per-row valid bits, so there is no clearing pass. csr_wdata
// sets the vertex count; values above 32 act as 32. write it only while the block is idle.
module euler_circuit_hierholzer import ech_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata
);

   // walk sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ADD   = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_ROW   = 3'd3;
   localparam logic [2:0] S_FETCH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CFG_W-1:0]  vcount_ff;
   logic [VERT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0]  stack_count_ff, stack_count_in;
   logic [CNT_W-1:0]  circ_count_ff, circ_count_in;
   logic [VERT_W-1:0] add_from_ff, add_from_in;
   logic [VERT_W-1:0] add_to_ff, add_to_in;
   logic              fetch_empty_ff, fetch_empty_in;
   logic              fetch_last_ff, fetch_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // adjacency memory: one row per source vertex, valid bits stand in for reset
   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_valid_ff;
   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic                    adj_rd_vld_ff;
   logic [VERT_W-1:0]       adj_rd_addr;
   logic                    adj_we;
   logic [VERT_W-1:0]       adj_wr_addr;
   logic [MAX_VERTICES-1:0] adj_wr_data;

   // walk stack and circuit store
   logic [VERT_W-1:0] stack_mem [PATH_DEPTH];
   logic [VERT_W-1:0] stk_rd_ff;
   logic              stk_rd_en;
   logic [ADDR_W-1:0] stk_rd_addr;
   logic              stk_we;
   logic [ADDR_W-1:0] stk_wr_addr;
   logic [VERT_W-1:0] stk_wr_data;

   logic [VERT_W-1:0] circ_mem [PATH_DEPTH];
   logic [VERT_W-1:0] circ_rd_ff;
   logic              circ_rd_en;
   logic [ADDR_W-1:0] circ_rd_addr;
   logic              circ_we;
   logic [ADDR_W-1:0] circ_wr_addr;

   logic                    accept;
   logic                    rsp_free;
   logic [CFG_W-1:0]        act_n;
   logic [MAX_VERTICES-1:0] act_mask;
   logic [MAX_VERTICES-1:0] row_raw;
   logic [MAX_VERTICES-1:0] row_use;
   logic                    top_in_range;
   logic                    edge_found;
   logic [VERT_W-1:0]       edge_target;
   logic [MAX_VERTICES-1:0] edge_bit;
   logic [CNT_W-1:0]        circ_dec;
   logic [CNT_W-1:0]        stack_dec2;

   // vertices in use, clamped to the matrix size
   always_comb begin
      act_n = (vcount_ff > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_ff;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         act_mask[i] = CFG_W'(i) < act_n;
      end
   end

   // an invalid row reads as no edges; stale edges outside the count are masked
   assign row_raw      = adj_rd_vld_ff ? adj_rd_ff : '0;
   assign top_in_range = CFG_W'(top_ff) < act_n;
   assign row_use      = top_in_range ? (row_raw & act_mask) : '0;

   ech_ffs u_ffs (
      .row    (row_use),
      .found  (edge_found),
      .index  (edge_target),
      .lowest (edge_bit)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign circ_dec   = circ_count_ff - CNT_W'(1);
   assign stack_dec2 = stack_count_ff - CNT_W'(2);

   always_comb begin
      state_in       = state_ff;
      top_in         = top_ff;
      stack_count_in = stack_count_ff;
      circ_count_in  = circ_count_ff;
      add_from_in    = add_from_ff;
      add_to_in      = add_to_ff;
      fetch_empty_in = fetch_empty_ff;
      fetch_last_in  = fetch_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      adj_rd_addr  = top_ff;
      adj_we       = 1'b0;
      adj_wr_addr  = top_ff;
      adj_wr_data  = row_raw & ~edge_bit;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = stack_dec2[ADDR_W-1:0];
      stk_we       = 1'b0;
      stk_wr_addr  = stack_count_ff[ADDR_W-1:0];
      stk_wr_data  = edge_target;
      circ_rd_en   = 1'b0;
      circ_rd_addr = circ_dec[ADDR_W-1:0];
      circ_we      = 1'b0;
      circ_wr_addr = circ_count_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            // row read of the source or start vertex goes out with the request
            adj_rd_addr = req_data.from_vertex;
            if (accept) begin
               case (req_data.command)
                  CMD_ADD: begin
                     add_from_in = req_data.from_vertex;
                     add_to_in   = req_data.to_vertex;
                     if ((CFG_W'(req_data.from_vertex) < act_n) &&
                         (CFG_W'(req_data.to_vertex) < act_n)) begin
                        state_in = S_ADD;
                     end
                  end
                  CMD_RUN: begin
                     top_in         = req_data.from_vertex;
                     stack_count_in = CNT_W'(1);
                     circ_count_in  = '0;
                     stk_we         = 1'b1;
                     stk_wr_addr    = '0;
                     stk_wr_data    = req_data.from_vertex;
                     state_in       = S_EVAL;
                  end
                  CMD_FETCH: begin
                     if (circ_count_ff == '0) begin
                        fetch_empty_in = 1'b1;
                        fetch_last_in  = 1'b0;
                     end else begin
                        fetch_empty_in = 1'b0;
                        fetch_last_in  = (circ_dec == '0);
                        circ_count_in  = circ_dec;
                        circ_rd_en     = 1'b1;
                     end
                     state_in = S_FETCH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD: begin
            adj_we      = 1'b1;
            adj_wr_addr = add_from_ff;
            adj_wr_data = row_raw | (MAX_VERTICES'(1) << add_to_ff);
            state_in    = S_IDLE;
         end
         S_EVAL: begin
            if (edge_found) begin
               // take the lowest out-edge and push its target if the stack has room
               adj_we = 1'b1;
               if (stack_count_ff < CNT_W'(PATH_DEPTH)) begin
                  stk_we         = 1'b1;
                  top_in         = edge_target;
                  stack_count_in = stack_count_ff + CNT_W'(1);
               end
               state_in = S_ROW;
            end else begin
               // dead end: pop the top vertex into the circuit store if it has room
               if (circ_count_ff < CNT_W'(PATH_DEPTH)) begin
                  circ_we       = 1'b1;
                  circ_count_in = circ_count_ff + CNT_W'(1);
               end
               stack_count_in = stack_count_ff - CNT_W'(1);
               if (stack_count_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  top_in   = stk_rd_ff;
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            // fetch the top row and the entry below it for a possible pop
            stk_rd_en = stack_count_ff >= CNT_W'(2);
            state_in  = S_EVAL;
         end
         S_FETCH: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.vertex    = fetch_empty_ff ? '0 : circ_rd_ff;
               rsp_data_in.last      = fetch_last_ff;
               rsp_data_in.empty_res = fetch_empty_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         vcount_ff      <= VCOUNT_RESET;
         stack_count_ff <= '0;
         circ_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         adj_valid_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= stack_count_in;
         circ_count_ff  <= circ_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            vcount_ff <= csr_wdata;
         end
         if (adj_we) begin
            adj_valid_ff[adj_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff         <= top_in;
      add_from_ff    <= add_from_in;
      add_to_ff      <= add_to_in;
      fetch_empty_ff <= fetch_empty_in;
      fetch_last_ff  <= fetch_last_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // adjacency memory
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wr_addr] <= adj_wr_data;
      end
      adj_rd_ff     <= adj_mem[adj_rd_addr];
      adj_rd_vld_ff <= adj_valid_ff[adj_rd_addr];
   end

   // walk stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wr_addr] <= stk_wr_data;
      end
      if (stk_rd_en) begin
         stk_rd_ff <= stack_mem[stk_rd_addr];
      end
   end

   // circuit store
   always_ff @(posedge clock) begin
      if (circ_we) begin
         circ_mem[circ_wr_addr] <= top_ff;
      end
      if (circ_rd_en) begin
         circ_rd_ff <= circ_mem[circ_rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stack never grows past its depth
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= CNT_W'(PATH_DEPTH))
      else $error("walk stack count beyond depth");

   // circuit store never grows past its depth
   a_circ_bound: assert property (@(posedge clock) disable iff (reset)
      circ_count_ff <= CNT_W'(PATH_DEPTH))
      else $error("circuit count beyond depth");

   // a step of the walk always has a top vertex
   a_eval_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (stack_count_ff != '0))
      else $error("walk step with empty stack");

   // the walk ends only by popping the last stack entry
   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && state_in == S_IDLE) |-> (stack_count_ff == CNT_W'(1)))
      else $error("walk left with entries on the stack");

   // a fetch with no circuit left returns the empty response
   a_fetch_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_FETCH && circ_count_ff == '0)
      |=> (state_ff == S_FETCH && fetch_empty_ff))
      else $error("empty fetch not flagged");

endmodule

// ----- tb/euler_circuit_hierholzer_tb.sv -----
`timescale 1ns / 1ps

module euler_circuit_hierholzer_tb;
   import ech_pkg::*;

   localparam int CLK_HALF_NS  = 5;
   localparam int RESET_CYCLES = 7;
   // settle time for a run over a full 32 x 32 matrix, no result meanwhile
   localparam int WALK_SETTLE  = 4 * MAX_VERTICES * MAX_VERTICES + 64;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 130;
   localparam int PHASES       = 12;
   localparam int PRESSURE_PHASE = 4;
   localparam int TIMEOUT_NS   = 10_000_000;

   typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_e;

   // clock, reset and block inputs, all known from time zero
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic [CFG_W-1:0] csr_wdata = VCOUNT_RESET;

   euler_circuit_hierholzer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   // shadow copy of the graph, the walk stack and the circuit
   logic [MAX_VERTICES-1:0] adj_rows   [MAX_VERTICES];
   logic [VERT_W-1:0]       walk_stk   [PATH_DEPTH];
   logic [VERT_W-1:0]       circ_store [PATH_DEPTH];
   int                      stk_depth;
   int                      circ_len;
   logic [CFG_W-1:0]        vcount_model;

   // vertices that fetch requests are due to return, oldest first
   rsp_type circuit_expect [$];
   req_type pending_reqs [$];

   int  reqs_queued = 0;
   int  reqs_taken = 0;
   int  phase_items = 0;
   int  mismatches = 0;
   int  n_adds = 0, n_runs = 0, n_fetches = 0, n_ignored = 0;
   int  vertices_checked = 0, empties_checked = 0;
   int  settings_used = 0;
   int  long_holds = 0;
   logic req_fire = 1'b0;
   bit  hold_toggle = 1'b0;

   // vertex count in use, values above the matrix size clamp to it
   function automatic int active_vertices();
      return (vcount_model > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_model);
   endfunction

   // hierholzer walk on the shadow matrix, fills circ_store in pop order
   function automatic void walk_circuit(input logic [VERT_W-1:0] start);
      int                      n;
      int                      v;
      int                      w;
      logic [MAX_VERTICES-1:0] mask;
      logic [MAX_VERTICES-1:0] row;
      n = active_vertices();
      mask = (n >= MAX_VERTICES) ? '1 : MAX_VERTICES'((64'd1 << n) - 64'd1);
      stk_depth = 0;
      circ_len = 0;
      walk_stk[0] = start;
      stk_depth = 1;
      while (stk_depth > 0) begin
         v = int'(walk_stk[stk_depth - 1]);
         // start beyond the vertex count, or stale edges, give an empty row
         row = (v < n) ? (adj_rows[v] & mask) : '0;
         if (row != '0) begin
            w = 0;
            while (!row[w]) w++;
            adj_rows[v][w] = 1'b0;
            // stack full: edge is consumed, target dropped
            if (stk_depth < PATH_DEPTH) begin
               walk_stk[stk_depth] = VERT_W'(w);
               stk_depth++;
            end
         end else begin
            // store full: popped vertex dropped
            if (circ_len < PATH_DEPTH) begin
               circ_store[circ_len] = VERT_W'(v);
               circ_len++;
            end
            stk_depth--;
         end
      end
   endfunction

   // apply one accepted request to the shadow state
   function automatic void predict_request(input req_type r);
      int      n;
      rsp_type e;
      n = active_vertices();
      case (r.command)
         CMD_ADD: begin
            n_adds++;
            // edges touching a vertex at or past the count are dropped
            if (int'(r.from_vertex) < n && int'(r.to_vertex) < n)
               adj_rows[r.from_vertex][r.to_vertex] = 1'b1;
         end
         CMD_RUN: begin
            n_runs++;
            walk_circuit(r.from_vertex);
         end
         CMD_FETCH: begin
            n_fetches++;
            e = '0;
            if (circ_len == 0) begin
               e.empty_res = 1'b1;
            end else begin
               circ_len--;
               e.vertex = circ_store[circ_len];
               e.last = (circ_len == 0);
            end
            circuit_expect.insert(circuit_expect.size(), e);
         end
         default: n_ignored++;
      endcase
   endfunction

   // monitor: responses are checked before the request of the same edge is applied
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
         stk_depth = 0;
         circ_len = 0;
         vcount_model = VCOUNT_RESET;
         req_fire <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (circuit_expect.size() == 0) begin
               $display("%0t: expected no response, actual vertex %0d last %0b empty %0b",
                        $time, rsp_data.vertex, rsp_data.last, rsp_data.empty_res);
               mismatches++;
            end else begin
               want = circuit_expect.pop_front();
               if (rsp_data.vertex !== want.vertex) begin
                  $display("%0t: vertex mismatch, expected %0d, actual %0d",
                           $time, want.vertex, rsp_data.vertex);
                  mismatches++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_data.last);
                  mismatches++;
               end
               if (rsp_data.empty_res !== want.empty_res) begin
                  $display("%0t: empty_res mismatch, expected %0b, actual %0b",
                           $time, want.empty_res, rsp_data.empty_res);
                  mismatches++;
               end
               if (want.empty_res) empties_checked++;
               else vertices_checked++;
            end
         end
         if (csr_we) vcount_model = csr_wdata;
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            reqs_taken++;
            predict_request(req_data);
         end
      end
   end

   // driver: bursts of requests with random gaps, payload held until taken
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: stall pattern redrawn at random from four modes,
   // plus a long hold-off whenever the stimulus flips hold_toggle
   rx_mode_e rx_mode = RX_OPEN;
   int       rx_mode_left = 0;
   int       hold_left = 0;
   bit       hold_seen = 1'b0;

   always @(negedge clock) begin : rsp_stall
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_toggle) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES - 1;
         long_holds++;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 96);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
            default:   rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic queue_req(input logic [1:0] cmd, input int from_v, input int to_v);
      req_type r;
      r.command = cmd;
      r.from_vertex = VERT_W'(from_v);
      r.to_vertex = VERT_W'(to_v);
      pending_reqs.insert(pending_reqs.size(), r);
      reqs_queued++;
      phase_items++;
   endtask

   // wait until every request is taken and every fetch answered
   task automatic wait_quiet(input int extra);
      while (reqs_taken != reqs_queued || circuit_expect.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // register write only once the block is idle, a run may still be walking
   task automatic write_vcount(input logic [CFG_W-1:0] value);
      wait_quiet(WALK_SETTLE);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // closed walk of len edges over vertices below span
   task automatic queue_cycle(input int span, input int len, output int first_v);
      int cur;
      int nxt;
      cur = $urandom_range(0, span - 1);
      first_v = cur;
      for (int i = 1; i < len; i++) begin
         nxt = $urandom_range(0, span - 1);
         queue_req(CMD_ADD, cur, nxt);
         cur = nxt;
      end
      queue_req(CMD_ADD, cur, first_v);
   endtask

   // sequence: closed walks, a run, then fetches of all or part of the circuit
   task automatic queue_walk(input int span, input int cycles, input int max_len);
      int start;
      int v0;
      int edges;
      int len;
      int fetches;
      edges = 0;
      start = 0;
      for (int k = 0; k < cycles; k++) begin
         len = $urandom_range(1, max_len);
         queue_cycle(span, len, v0);
         if (k == 0) start = v0;
         edges += len;
      end
      // now and then start anywhere, in range or not
      if ($urandom_range(0, 9) == 0) start = $urandom_range(0, 31);
      queue_req(CMD_RUN, start, $urandom_range(0, 31));
      fetches = edges + 1 + $urandom_range(0, 2);
      // partial read, the next run throws the rest away
      if ($urandom_range(0, 5) == 0) fetches = $urandom_range(0, edges);
      repeat (fetches) queue_req(CMD_FETCH, $urandom_range(0, 31), $urandom_range(0, 31));
   endtask

   // random requests of any command, unknown one included
   task automatic queue_noise(input int count);
      repeat (count)
         queue_req(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31));
   endtask

   initial begin : stimulus
      int vc_plan [PHASES];
      int span;
      int pick;
      vc_plan = '{63, 1, 2, 33, 5, 3, 8, 32, 16, 6, 0, 32};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count of 32: extreme vertices, duplicate edge, self loop,
      // unknown command, fetch before any run, circuit 0 31 0, then empty
      queue_req(CMD_ADD, 0, 31);
      queue_req(CMD_ADD, 31, 0);
      queue_req(CMD_ADD, 0, 31);
      queue_req(CMD_ADD, 5, 5);
      queue_req(2'b11, 31, 31);
      queue_req(CMD_FETCH, 0, 0);
      queue_req(CMD_RUN, 0, 0);
      repeat (4) queue_req(CMD_FETCH, 0, 0);

      // four vertices: out-of-range edges ignored, start past the count
      // with a stale self loop gives the one-vertex circuit, then a self loop
      write_vcount(CFG_W'(4));
      queue_req(CMD_ADD, 1, 6);
      queue_req(CMD_ADD, 6, 1);
      queue_req(CMD_ADD, 4, 0);
      queue_req(CMD_RUN, 5, 0);
      repeat (2) queue_req(CMD_FETCH, 0, 0);
      queue_req(CMD_ADD, 3, 3);
      queue_req(CMD_RUN, 3, 0);
      repeat (2) queue_req(CMD_FETCH, 0, 0);

      // zero vertices: every edge dropped, run gives just its start
      write_vcount(CFG_W'(0));
      queue_req(CMD_ADD, 0, 0);
      queue_req(CMD_RUN, 0, 0);
      repeat (2) queue_req(CMD_FETCH, 0, 0);

      // random phases over a range of vertex counts
      for (int p = 0; p < PHASES; p++) begin
         write_vcount(CFG_W'(vc_plan[p]));
         span = (vc_plan[p] > MAX_VERTICES) ? MAX_VERTICES : vc_plan[p];
         if (span == 0) span = 4;
         phase_items = 0;
         // long response hold-off while fetches keep coming, fills the output
         if (p == PRESSURE_PHASE) hold_toggle = ~hold_toggle;
         // complete graph with self loops on eight vertices
         if (vc_plan[p] == 8) begin
            for (int a = 0; a < 8; a++)
               for (int b = 0; b < 8; b++) queue_req(CMD_ADD, a, b);
            queue_req(CMD_RUN, $urandom_range(0, 7), 0);
            repeat (66) queue_req(CMD_FETCH, $urandom_range(0, 31), $urandom_range(0, 31));
         end
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
               queue_noise($urandom_range(1, 6));
            else if (pick == 2 && span == MAX_VERTICES)
               queue_walk(span, 4, 48);
            else
               queue_walk(span, $urandom_range(1, 3), (span < 8) ? 2 * span : 12);
         end
      end

      wait_quiet(DRAIN_CYCLES);
      $display("covered %0d requests: %0d adds, %0d runs, %0d fetches, %0d unknown",
               reqs_taken, n_adds, n_runs, n_fetches, n_ignored);
      $display("checked %0d vertices, %0d empty fetches, %0d count settings, %0d hold-offs",
               vertices_checked, empties_checked, settings_used, long_holds);
      if (mismatches == 0)
         $display("euler_circuit_hierholzer_tb: done, clean");
      else
         $display("euler_circuit_hierholzer_tb: done, errors");
      $finish;
   end

   // hard limit in case the block hangs
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("%0t: timeout, %0d of %0d requests taken, %0d fetches unanswered",
               $time, reqs_taken, reqs_queued, circuit_expect.size());
      $display("euler_circuit_hierholzer_tb: done, errors");
      $finish;
   end

endmodule
